>>> src/pfd_pkg.sv
`default_nettype none
package pfd_pkg;
  localparam logic [30:0] FIELD_P = 31'd2013265921;
  localparam logic [30:0] FIELD_P_MINUS_2 = 31'd2013265919;
  localparam logic [31:0] BARRETT_M = 32'd2290649223;
  localparam logic [3:0] REG_MATRIX_SIZE = 4'd0;

  function automatic logic [30:0] fsub(input logic [30:0] x, input logic [30:0] y);
    logic [31:0] s;
    s = {1'b0, x} + {1'b0, FIELD_P} - {1'b0, y};
    if (x >= y) fsub = x - y;
    else fsub = s[30:0];
  endfunction
endpackage
`default_nettype wire

>>> src/pfd_ram.sv
`default_nettype none
module pfd_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> src/pfd_mulmod.sv
`default_nettype none
module pfd_mulmod (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [30:0] a,
  input  wire logic [30:0] b,
  output logic             done,
  output logic [30:0]      y
);
  import pfd_pkg::*;
  logic [61:0] prod_r;
  logic [63:0] t_r;
  logic [32:0] qp_r;
  logic [32:0] x1_r, x2_r;
  logic        s1_r, s2_r, s3_r;
  logic [32:0] r0, r1, r2;
  always_comb begin
    r0 = x2_r - qp_r;
    r1 = (r0 >= {2'b0, FIELD_P}) ? r0 - {2'b0, FIELD_P} : r0;
    r2 = (r1 >= {2'b0, FIELD_P}) ? r1 - {2'b0, FIELD_P} : r1;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= 1'b0; s2_r <= 1'b0; s3_r <= 1'b0; done <= 1'b0;
    end else begin
      s1_r <= start;
      s2_r <= s1_r;
      s3_r <= s2_r;
      done <= s3_r;
    end
    if (start) prod_r <= 62'(a) * 62'(b);
    if (s1_r) begin
      t_r <= 64'(prod_r[61:30]) * 64'(BARRETT_M);
      x1_r <= prod_r[32:0];
    end
    if (s2_r) begin
      qp_r <= 33'(t_r[63:32]) * 33'(FIELD_P);
      x2_r <= x1_r;
    end
    if (s3_r) y <= r2[30:0];
  end
endmodule
`default_nettype wire

>>> src/prime_field_determinant_unit.sv
`default_nettype none
// Channel  Direction  Ports
// in       input      in_valid, in_stall, in_entry_value
// out      output     out_valid, out_stall, out_determinant
// cfg      APB        cfg_psel .. cfg_pready
// Entries load at one per cycle while in_stall is low; the last entry starts elimination.
// Elimination uses one shared pipelined modular multiplier with reciprocal
// reduction, so a matrix of side n takes on the order of n^3 multiplies plus
// 31 squarings per pivot inverse.
// in_stall stays high during elimination, while a result waits and during a
// configuration write.
// Reset is synchronous; matrix_size returns to 4 and the load count to zero.
module prime_field_determinant_unit #(
  parameter int MAX_DIM = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [30:0] in_entry_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [30:0]      out_determinant,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import pfd_pkg::*;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = $clog2(DEPTH) < 1 ? 1 : $clog2(DEPTH);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    S_LOAD, S_COL, S_PRD, S_PCHK, S_SWRA, S_SWRB, S_SWW1, S_SWW2,
    S_DET, S_DETW, S_PWR, S_PWW, S_PSQ, S_PSQW, S_ROW, S_RCHK, S_FMUL,
    S_FMW, S_CRD, S_CRB, S_CMUL, S_CMW, S_OUT
  } state_t;

  state_t state_r;
  logic [3:0]    size_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] n_r, col_r, row_r, c_r, piv_r;
  logic [30:0]   det_r, inv_r, base_r, f_r, a_r, tmp_r;
  logic [4:0]    bit_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [30:0]   wdata, rdata;
  logic          ms, md;
  logic [30:0]   ma, mb, my;

  pfd_ram #(.WIDTH(31), .DEPTH(DEPTH)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );
  pfd_mulmod u_mul (.clk, .rst_n, .start(ms), .a(ma), .b(mb), .done(md), .y(my));

  logic [DW-1:0] side;
  always_comb begin
    if (size_r == 4'd0) side = DW'(1);
    else if (32'(size_r) > MAX_DIM) side = DW'(MAX_DIM);
    else side = DW'(size_r);
  end

  function automatic logic [AW-1:0] ad(input logic [DW-1:0] r, input logic [DW-1:0] c,
                                       input logic [DW-1:0] n);
    ad = AW'(32'(r) * 32'(n) + 32'(c));
  endfunction

  logic [CW-1:0] total;
  logic in_acc, cfg_wr;
  logic [30:0] v_red;
  assign total = CW'(32'(side) * 32'(side));
  assign in_stall = (state_r != S_LOAD) || cfg_wr;
  assign in_acc = in_valid && !in_stall;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == REG_MATRIX_SIZE[1:0]) ? {28'd0, size_r} : 32'd0;
  assign v_red = (in_entry_value >= FIELD_P) ? in_entry_value - FIELD_P : in_entry_value;
  assign out_valid = (state_r == S_OUT);
  assign out_determinant = det_r;

  logic [31:0] pm2;
  assign pm2 = {1'b0, FIELD_P_MINUS_2};

  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0; ms = 1'b0; ma = '0; mb = '0;
    case (state_r)
      S_LOAD: begin
        we = in_acc; waddr = AW'(cnt_r); wdata = v_red;
      end
      S_PRD: raddr = ad(row_r, col_r, n_r);
      S_SWRA: raddr = ad(piv_r, c_r, n_r);
      S_SWRB: raddr = ad(col_r, c_r, n_r);
      S_SWW1: begin
        we = 1'b1; waddr = ad(piv_r, c_r, n_r); wdata = rdata;
      end
      S_SWW2: begin
        we = 1'b1; waddr = ad(col_r, c_r, n_r); wdata = tmp_r;
      end
      S_DET: begin ms = 1'b1; ma = det_r; mb = base_r; end
      S_PWR: begin ms = pm2[bit_r]; ma = inv_r; mb = base_r; end
      S_PSQ: begin ms = 1'b1; ma = base_r; mb = base_r; end
      S_ROW: raddr = ad(row_r, col_r, n_r);
      S_FMUL: begin ms = 1'b1; ma = f_r; mb = inv_r; end
      S_CRD: raddr = ad(col_r, c_r, n_r);
      S_CRB: raddr = ad(row_r, c_r, n_r);
      S_CMUL: begin ms = 1'b1; ma = f_r; mb = tmp_r; end
      S_CMW: begin
        we = md; waddr = ad(row_r, c_r, n_r); wdata = fsub(a_r, my);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; size_r <= 4'd4; cnt_r <= '0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (cfg_wr) begin
            if (cfg_paddr == REG_MATRIX_SIZE[1:0]) begin
              size_r <= cfg_pwdata[3:0]; cnt_r <= '0;
            end
          end else if (in_acc) begin
            if (cnt_r + CW'(1) >= total) begin
              cnt_r <= '0; n_r <= side; col_r <= '0; det_r <= 31'd1;
              state_r <= S_COL;
            end else cnt_r <= cnt_r + CW'(1);
          end
        end
        S_COL: begin
          if (col_r == n_r) state_r <= S_OUT;
          else begin row_r <= col_r; state_r <= S_PRD; end
        end
        S_PRD: state_r <= S_PCHK;
        S_PCHK: begin
          if (rdata != 31'd0) begin
            piv_r <= row_r; base_r <= rdata; c_r <= '0;
            if (row_r != col_r) begin
              det_r <= fsub(31'd0, det_r); state_r <= S_SWRA;
            end else state_r <= S_DET;
          end else if (row_r + DW'(1) == n_r) begin
            det_r <= 31'd0; state_r <= S_OUT;
          end else begin
            row_r <= row_r + DW'(1); state_r <= S_PRD;
          end
        end
        S_SWRA: state_r <= S_SWRB;
        S_SWRB: begin tmp_r <= rdata; state_r <= S_SWW1; end
        S_SWW1: state_r <= S_SWW2;
        S_SWW2: begin
          if (c_r + DW'(1) == n_r) state_r <= S_DET;
          else begin c_r <= c_r + DW'(1); state_r <= S_SWRA; end
        end
        S_DET: state_r <= S_DETW;
        S_DETW: if (md) begin
          det_r <= my; inv_r <= 31'd1; bit_r <= '0; state_r <= S_PWR;
        end
        S_PWR: begin
          if (pm2[bit_r]) state_r <= S_PWW;
          else state_r <= S_PSQ;
        end
        S_PWW: if (md) begin inv_r <= my; state_r <= S_PSQ; end
        S_PSQ: state_r <= S_PSQW;
        S_PSQW: if (md) begin
          base_r <= my;
          if (bit_r == 5'd30) begin row_r <= col_r + DW'(1); state_r <= S_ROW; end
          else begin bit_r <= bit_r + 5'd1; state_r <= S_PWR; end
        end
        S_ROW: begin
          if (row_r == n_r) begin col_r <= col_r + DW'(1); state_r <= S_COL; end
          else state_r <= S_RCHK;
        end
        S_RCHK: begin
          if (rdata == 31'd0) begin row_r <= row_r + DW'(1); state_r <= S_ROW; end
          else begin f_r <= rdata; state_r <= S_FMUL; end
        end
        S_FMUL: state_r <= S_FMW;
        S_FMW: if (md) begin f_r <= my; c_r <= col_r; state_r <= S_CRD; end
        S_CRD: state_r <= S_CRB;
        S_CRB: begin tmp_r <= rdata; state_r <= S_CMUL; end
        S_CMUL: begin a_r <= rdata; state_r <= S_CMW; end
        S_CMW: if (md) begin
          if (c_r + DW'(1) == n_r) begin row_r <= row_r + DW'(1); state_r <= S_ROW; end
          else begin c_r <= c_r + DW'(1); state_r <= S_CRD; end
        end
        S_OUT: if (!out_stall) state_r <= S_LOAD;
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire
